>>> design/aac_pkg.sv
// Shared types and constants for the alarm annunciator controller.
package aac_pkg;

  localparam int ALARM_COUNT_DEF = 6;
  localparam int IDX_W = 3;
  localparam int CNT_W = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [1:0] MODE_RAISE = 2'd0;
  localparam logic [1:0] MODE_MUTE = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  localparam logic [1:0] EVT_NONE = 2'd0;
  localparam logic [1:0] EVT_OFF = 2'd1;
  localparam logic [1:0] EVT_ON = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_SOUND_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNLIMITED = 1'd1;

  localparam logic [CNT_W-1:0] SOUND_LIMIT_RST = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] alarm_index;
  } req_t;

  typedef struct packed {
    logic             buzzer_on;
    logic             display_active;
    logic [IDX_W-1:0] display_alarm;
    logic [1:0]       display_event;
    logic             bad_index;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] limit;
    logic             unlimited;
  } cfg_t;

  typedef struct packed {
    logic set_pending;
    logic mute_clear;
    logic clear_all;
  } cell_cmd_t;

  typedef struct packed {
    logic muted;
    logic hit;
    logic pass;
    logic pend;
  } cell_stat_t;

endpackage

>>> design/aac_cell.sv
// One alarm cell: pending flag, sound count and the scan token stage.
module aac_cell import aac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  logic       sel,
  input  cfg_t       cfg,
  input  logic       tok_in,
  output cell_stat_t stat
);

  logic             pending;
  logic [CNT_W-1:0] count;
  logic             tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      count   <= '0;
      tok     <= 1'b0;
    end else begin
      tok <= tok_in;
      if (cmd.clear_all) begin
        pending <= 1'b0;
        count   <= '0;
      end else if (sel && cmd.set_pending) begin
        pending <= 1'b1;
      end else if (sel && cmd.mute_clear) begin
        pending <= 1'b0;
        if (!cfg.unlimited && (count < cfg.limit)) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    stat.muted = !cfg.unlimited && (count >= cfg.limit);
    stat.hit   = tok && pending;
    stat.pass  = tok && !pending;
    stat.pend  = pending;
  end

endmodule

>>> design/alarm_annunciator_controller.sv
// Alarm annunciator top level: command decode, scan control and the row of alarm cells.
//
//   channel | direction | handshake           | beat
//   req     | in        | req_valid/req_stall | mode, alarm_index
//   rsp     | out       | rsp_valid/rsp_stall | buzzer, display state and event, bad index
//   cfg     | in        | cfg_valid/cfg_ready | register index, write data
//
// A beat with no display search (bad index, raise with an alarm shown, mute with nothing
// shown, reset all, unused mode) goes straight to the done state; one that searches
// walks the token one cell per cycle until the lowest pending alarm is found. One
// beat at a time; req_stall is high from acceptance until the result is
// loaded. The result waits in the output register while rsp_stall is high; the next beat
// may be taken meanwhile. Reset (rst, synchronous) clears all alarm state and
// sets sound_limit to 3, unlimited_sound to 0.
module alarm_annunciator_controller import aac_pkg::*; #(
  parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_t                   rsp,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  state_t state;
  state_t state_next;

  cfg_t             cfg;
  logic             buzzer;
  logic             shown_valid;
  logic [IDX_W-1:0] shown_index;
  logic [1:0]       evt;
  logic             bad;
  logic             sound;

  cell_cmd_t              cmd;
  logic [ALARM_COUNT-1:0] sel;
  logic [ALARM_COUNT-1:0] sel_req;
  logic [ALARM_COUNT-1:0] sel_shown;
  logic [ALARM_COUNT-1:0] tok_in;
  cell_stat_t             stat [ALARM_COUNT];
  logic [ALARM_COUNT-1:0] muted_vec;
  logic [ALARM_COUNT-1:0] hit_vec;
  logic [ALARM_COUNT-1:0] pend_vec;

  logic             accept;
  logic             load;
  logic             scan_start;
  logic             hit_any;
  logic             hit_muted;
  logic [IDX_W-1:0] hit_index;
  logic             scan_end;
  logic             idx_bad;
  logic             req_muted;

  // cell row
  for (genvar i = 0; i < ALARM_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = scan_start;
    end else begin : g_link
      assign tok_in[i] = stat[i-1].pass;
    end
    aac_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .sel    (sel[i]),
      .cfg    (cfg),
      .tok_in (tok_in[i]),
      .stat   (stat[i])
    );
    assign muted_vec[i] = stat[i].muted;
    assign hit_vec[i]   = stat[i].hit;
    assign pend_vec[i]  = stat[i].pend;
    assign sel_req[i]   = (req.alarm_index == IDX_W'(i));
    assign sel_shown[i] = (shown_index == IDX_W'(i));
  end

  assign scan_end = stat[ALARM_COUNT-1].pass;

  always_comb begin
    hit_index = '0;
    for (int i = 0; i < ALARM_COUNT; i++) begin
      if (hit_vec[i]) begin
        hit_index = hit_index | IDX_W'(i);
      end
    end
  end

  assign hit_any   = |hit_vec;
  assign hit_muted = |(hit_vec & muted_vec);
  assign req_muted = |(sel_req & muted_vec);
  assign idx_bad   = ({1'b0, req.alarm_index} >= (IDX_W + 1)'(ALARM_COUNT));

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit     <= SOUND_LIMIT_RST;
      cfg.unlimited <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOUND_LIMIT: cfg.limit <= cfg_data;
        REG_UNLIMITED:   cfg.unlimited <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = scan_start ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (hit_any || scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs and beat decode
  always_comb begin
    req_stall  = (state != ST_IDLE);
    accept     = (state == ST_IDLE) && req_valid;
    load       = (state == ST_DONE) && (!rsp_valid || !rsp_stall);
    cmd        = '0;
    sel        = '0;
    scan_start = 1'b0;
    if (accept) begin
      case (req.mode)
        MODE_RAISE: begin
          cmd.set_pending = !idx_bad;
          sel             = sel_req;
          scan_start      = !idx_bad && !shown_valid;
        end
        MODE_MUTE: begin
          cmd.mute_clear = shown_valid;
          sel            = sel_shown;
          scan_start     = shown_valid;
        end
        MODE_RESET: begin
          cmd.clear_all = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      buzzer      <= 1'b0;
      shown_valid <= 1'b0;
      shown_index <= '0;
      evt         <= EVT_NONE;
      bad         <= 1'b0;
      sound       <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        evt <= EVT_NONE;
        bad <= 1'b0;
        case (req.mode)
          MODE_RAISE: begin
            if (idx_bad) begin
              bad <= 1'b1;
            end else begin
              sound <= 1'b0;
              if (!req_muted) begin
                buzzer <= 1'b1;
              end
            end
          end
          MODE_MUTE: begin
            if (shown_valid) begin
              buzzer      <= 1'b0;
              shown_valid <= 1'b0;
              shown_index <= '0;
              evt         <= EVT_OFF;
              sound       <= 1'b1;
            end
          end
          MODE_RESET: begin
            buzzer      <= 1'b0;
            shown_valid <= 1'b0;
            shown_index <= '0;
            evt         <= EVT_OFF;
          end
          default: ;
        endcase
      end else if ((state == ST_SCAN) && hit_any) begin
        shown_valid <= 1'b1;
        shown_index <= hit_index;
        evt         <= evt | EVT_ON;
        if (sound && !hit_muted) begin
          buzzer <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.buzzer_on      <= buzzer;
      rsp.display_active <= shown_valid;
      rsp.display_alarm  <= shown_valid ? shown_index : '0;
      rsp.display_event  <= evt;
      rsp.bad_index      <= bad;
    end
  end

  // checks
  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell claims the scan token");

  a_shown_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && shown_valid |-> (pend_vec & sel_shown) != '0)
    else $error("alarm on display is not pending");

  a_scan_shows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && hit_any |=> shown_valid && (state == ST_DONE))
    else $error("scan hit did not put an alarm on display");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode == MODE_RESET) |=> (pend_vec == '0) && !shown_valid && !buzzer)
    else $error("reset all left alarm state behind");

endmodule
